// ===== rtl/brp_pkg.sv =====
// Shared types, constants and helpers of the binomial pyramid reduce block.
// No dependencies; every other file but brp_checker imports it.
`timescale 1ns / 1ps

package brp_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int CHANNEL_BITS = 16;
   localparam int CHAN_W       = 16;
   localparam int NCH          = 4;
   localparam int NSLOT        = 3;
   localparam int NTAP         = 6;
   localparam int HALF_MAX     = (MAX_WIDTH + 1) / 2;
   localparam int ADDR_W       = $clog2(HALF_MAX);
   localparam int CFG_W        = 12;
   localparam int POS_W        = CFG_W + 1;
   localparam int HSUM_W       = CHANNEL_BITS + 5;
   localparam int ACC_W        = CHANNEL_BITS + 10;
   localparam int CSR_IDX_W    = 4;
   localparam int RND_SHIFT    = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_IN_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IN_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CFG_W-1:0]     CFG_RESET     = CFG_W'(2048);
   localparam logic [CHAN_W-1:0]    CHAN_MASK     =
      CHAN_W'((64'd1 << CHANNEL_BITS) - 64'd1);

   typedef logic [NCH-1:0][CHAN_W-1:0] pix_type;
   typedef logic [NCH-1:0][HSUM_W-1:0] hsum_type;
   typedef logic [NCH-1:0][ACC_W-1:0]  acc_type;
   typedef acc_type [NSLOT-1:0]        acc_word_type;

   typedef enum logic [1:0] {WT_ONE, WT_FIVE, WT_TEN} wt_type;

   typedef struct packed {
      logic   en;
      logic   fresh;
      wt_type wt;
   } slot_op_type;

   typedef struct packed {
      logic                      complete;
      logic [ADDR_W-1:0]         addr;
      slot_op_type [NSLOT-1:0]   op;
      logic                      out_en;
      logic [1:0]                out_slot;
      logic                      row_end;
      logic                      frame_end;
   } vctl_type;

   typedef struct packed {
      logic [POS_W-1:0] w;
      logic [POS_W-1:0] h;
      logic [POS_W-1:0] hw;
      logic [POS_W-1:0] hh;
   } geom_type;

   typedef struct packed {
      logic    frame_end;
      logic    row_end;
      pix_type res;
   } out_word_type;

   function automatic logic [ACC_W-1:0] weigh(logic [HSUM_W-1:0] v, wt_type wt);
      logic [ACC_W-1:0] e;
      logic [ACC_W-1:0] r;
      e = ACC_W'(v);
      case (wt)
         WT_ONE:  r = e;
         WT_FIVE: r = (e << 2) + e;
         WT_TEN:  r = (e << 3) + (e << 1);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [CHAN_W-1:0] round_chan(logic [ACC_W-1:0] s);
      logic [ACC_W:0] t;
      t = {1'b0, s} + (ACC_W+1)'(1 << (RND_SHIFT - 1));
      return CHAN_W'(t >> RND_SHIFT);
   endfunction

endpackage

// ===== rtl/brp_hfilt.sv =====
// Raster position counters, 6-tap column window and horizontal sum stage.
// Depends on brp_pkg.
`timescale 1ns / 1ps

module brp_hfilt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    accept,
   input  logic                    restart,
   input  brp_pkg::pix_type        pix,
   input  brp_pkg::geom_type       geom,
   output logic                    rd_en,
   output logic [brp_pkg::ADDR_W-1:0] rd_addr,
   output logic                    b_valid,
   output brp_pkg::vctl_type       b_ctl,
   output brp_pkg::hsum_type       b_hsum
);
   import brp_pkg::*;

   logic [POS_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [1:0]       kmod_ff, kmod_in;
   logic             a_valid_ff, a_valid_in, b_valid_ff, b_valid_in;
   pix_type          win_ff [NTAP];
   vctl_type         a_ctl_ff, a_ctl_in, b_ctl_ff;
   hsum_type         hsum_in, hsum_ff;
   pix_type          pix_z;

   logic [POS_W-1:0] xh, k;
   logic             yodd, v_k, v_kp1, v_km1, rend;
   logic [1:0]       s_k, s_kp1, s_km1;

   always_comb begin
      xh    = x_ff >> 1;
      k     = y_ff >> 1;
      yodd  = y_ff[0];
      v_k   = k < geom.hh;
      v_kp1 = (k + POS_W'(1)) < geom.hh;
      v_km1 = (k != '0) && (k <= geom.hh);
      rend  = xh == geom.hw;
      s_k   = kmod_ff;
      s_kp1 = (kmod_ff == 2'd2) ? 2'd0 : kmod_ff + 2'd1;
      s_km1 = (kmod_ff == 2'd0) ? 2'd2 : kmod_ff - 2'd1;

      a_ctl_in.complete  = x_ff[0] && (x_ff >= POS_W'(3));
      a_ctl_in.addr      = ADDR_W'(xh - POS_W'(1));
      a_ctl_in.out_en    = yodd && v_km1;
      a_ctl_in.out_slot  = s_km1;
      a_ctl_in.row_end   = rend;
      a_ctl_in.frame_end = rend && (k == geom.hh);
      for (int s = 0; s < NSLOT; s++) begin
         if (2'(s) == s_k) begin
            a_ctl_in.op[s].en    = v_k;
            a_ctl_in.op[s].fresh = (y_ff == '0);
            a_ctl_in.op[s].wt    = WT_TEN;
         end else if (2'(s) == s_kp1) begin
            a_ctl_in.op[s].en    = v_kp1;
            a_ctl_in.op[s].fresh = !yodd;
            a_ctl_in.op[s].wt    = yodd ? WT_FIVE : WT_ONE;
         end else begin
            a_ctl_in.op[s].en    = v_km1;
            a_ctl_in.op[s].fresh = 1'b0;
            a_ctl_in.op[s].wt    = yodd ? WT_ONE : WT_FIVE;
         end
      end

      for (int c = 0; c < NCH; c++) begin
         pix_z[c] = ((x_ff < geom.w) && (y_ff < geom.h)) ? (pix[c] & CHAN_MASK) : '0;
      end

      // taps 1 5 10 10 5 1, newest column in win_ff[0]
      for (int c = 0; c < NCH; c++) begin
         hsum_in[c] = HSUM_W'(win_ff[0][c]) + HSUM_W'(win_ff[5][c])
                    + ((HSUM_W'(win_ff[1][c]) + HSUM_W'(win_ff[4][c])) * HSUM_W'(5))
                    + ((HSUM_W'(win_ff[2][c]) + HSUM_W'(win_ff[3][c])) * HSUM_W'(10));
      end

      // raster advance
      x_in    = x_ff;
      y_in    = y_ff;
      kmod_in = kmod_ff;
      if (restart) begin
         x_in    = '0;
         y_in    = '0;
         kmod_in = 2'd0;
      end else if (accept) begin
         if (x_ff >= ((geom.hw << 1) + POS_W'(1))) begin
            x_in = '0;
            if (y_ff >= ((geom.hh << 1) + POS_W'(1))) begin
               y_in    = '0;
               kmod_in = 2'd0;
            end else begin
               y_in = y_ff + POS_W'(1);
               if (yodd) kmod_in = s_kp1;
            end
         end else begin
            x_in = x_ff + POS_W'(1);
         end
      end

      a_valid_in = adv ? accept : a_valid_ff;
      b_valid_in = adv ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff       <= '0;
         y_ff       <= '0;
         kmod_ff    <= 2'd0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         x_ff       <= x_in;
         y_ff       <= y_in;
         kmod_ff    <= kmod_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ctl_ff  <= a_ctl_in;
         win_ff[0] <= pix_z;
         for (int t = 1; t < NTAP; t++) begin
            win_ff[t] <= (x_ff == '0) ? pix_type'('0) : win_ff[t-1];
         end
      end
      if (adv) begin
         b_ctl_ff <= a_ctl_ff;
         hsum_ff  <= hsum_in;
      end
   end

   assign rd_en   = adv && a_valid_ff && a_ctl_ff.complete;
   assign rd_addr = a_ctl_ff.addr;
   assign b_valid = b_valid_ff;
   assign b_ctl   = b_ctl_ff;
   assign b_hsum  = hsum_ff;

endmodule

// ===== rtl/brp_vaccum.sv =====
// Vertical pass: line accumulator memory, read-modify-write of three row slots.
// Depends on brp_pkg.
`timescale 1ns / 1ps

module brp_vaccum (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       rd_en,
   input  logic [brp_pkg::ADDR_W-1:0] rd_addr,
   input  logic                       b_valid,
   input  brp_pkg::vctl_type          b_ctl,
   input  brp_pkg::hsum_type          b_hsum,
   output logic                       push,
   output brp_pkg::out_word_type      push_word
);
   import brp_pkg::*;

   acc_word_type mem [HALF_MAX];
   acc_word_type rdata_ff, new_word;
   acc_type      sel, c_sum_ff;
   logic         c_valid_ff, c_valid_in, c_row_ff, c_frame_ff;
   logic         wr_en;

   always_comb begin
      for (int s = 0; s < NSLOT; s++) begin
         for (int c = 0; c < NCH; c++) begin
            new_word[s][c] = b_ctl.op[s].en
               ? ((b_ctl.op[s].fresh ? '0 : rdata_ff[s][c]) + weigh(b_hsum[c], b_ctl.op[s].wt))
               : rdata_ff[s][c];
         end
      end
      case (b_ctl.out_slot)
         2'd0:    sel = new_word[0];
         2'd1:    sel = new_word[1];
         2'd2:    sel = new_word[2];
         default: sel = new_word[0];
      endcase
      wr_en      = adv && b_valid && b_ctl.complete;
      c_valid_in = adv ? (b_valid && b_ctl.complete && b_ctl.out_en) : c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= mem[rd_addr];
      if (wr_en) mem[b_ctl.addr] <= new_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_sum_ff   <= sel;
         c_row_ff   <= b_ctl.row_end;
         c_frame_ff <= b_ctl.frame_end;
      end
   end

   always_comb begin
      push                = adv && c_valid_ff;
      push_word.row_end   = c_row_ff;
      push_word.frame_end = c_frame_ff;
      for (int c = 0; c < NCH; c++) begin
         push_word.res[c] = round_chan(c_sum_ff[c]);
      end
   end

endmodule

// ===== rtl/brp_skid.sv =====
// Output register with skid stage; its fill state gates the whole pipeline.
// Depends on brp_pkg.
`timescale 1ns / 1ps

module brp_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  brp_pkg::out_word_type push_word,
   input  logic                  out_ready,
   output logic                  out_valid,
   output brp_pkg::out_word_type out_word,
   output logic                  adv
);
   import brp_pkg::*;

   logic         main_v_ff, main_v_in, skid_v_ff, skid_v_in, take;
   out_word_type main_ff, main_in, skid_ff, skid_in;

   always_comb begin
      take      = main_v_ff && out_ready;
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      main_in   = main_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         if (take) begin
            main_in   = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         if (!main_v_ff || take) begin
            main_in   = push_word;
            main_v_in = 1'b1;
         end else begin
            skid_in   = push_word;
            skid_v_in = 1'b1;
         end
      end else if (take) begin
         main_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_v_ff;
   assign out_word  = main_ff;
   assign adv       = !skid_v_ff;

endmodule

// ===== rtl/binomial_pyramid_reduce.sv =====
// Top level of the 2x binomial (1 5 10 10 5 1)/32 pyramid reduce block.
// Depends on brp_pkg, brp_hfilt, brp_vaccum, brp_skid.
`timescale 1ns / 1ps
//
// Channel | Direction | Word
// --------+-----------+----------------------------------------------------
// req_    | in        | tdata: chan_a, chan_r, chan_g, chan_b (16 b each)
// rsp_    | out       | tdata: res_a..res_b, tlast: row_end, tuser: frame_end
// csr_    | in        | index 0 = in_width, 1 = in_height, data 12 b
//
// One word accepted per clock when the output side keeps up; the word that
// completes a result passes the a, b, c and output registers.
// Only the output side limits the rate: the accumulator memory sees one read
// and one write of a 3-row-slot word every second word (odd columns).
// Reset is synchronous; the accumulator memory needs no clearing pass.
// A stalled output fills the skid stage, which drops req_tready and freezes
// the pipeline until the consumer takes a word.

module binomial_pyramid_reduce (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [63:0]                   req_tdata,   // chan_a, chan_r, chan_g, chan_b
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,   // res_a, res_r, res_g, res_b
   output logic                          rsp_tlast,   // row_end
   output logic [0:0]                    rsp_tuser,   // frame_end
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [brp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [brp_pkg::CFG_W-1:0]     csr_data
);
   import brp_pkg::*;

   logic [CFG_W-1:0] width_ff, width_in, height_ff, height_in;
   logic             restart, adv, accept, rd_en, b_valid, push;
   logic [ADDR_W-1:0] rd_addr;
   geom_type         geom;
   vctl_type         b_ctl;
   hsum_type         b_hsum;
   out_word_type     push_word, out_word;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_valid) begin
         if (csr_index == CSR_IN_WIDTH) begin
            width_in = csr_data;
            restart  = 1'b1;
         end else if (csr_index == CSR_IN_HEIGHT) begin
            height_in = csr_data;
            restart   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_RESET;
         height_ff <= CFG_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // effective geometry: zero acts as one, width clamps to the line memory
   always_comb begin
      geom.w = POS_W'(width_ff);
      if (width_ff == '0) geom.w = POS_W'(1);
      else if (32'(width_ff) > MAX_WIDTH) geom.w = POS_W'(MAX_WIDTH);
      geom.h  = (height_ff == '0) ? POS_W'(1) : POS_W'(height_ff);
      geom.hw = (geom.w + POS_W'(1)) >> 1;
      geom.hh = (geom.h + POS_W'(1)) >> 1;
   end

   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   brp_hfilt u_hfilt (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .accept  (accept),
      .restart (restart),
      .pix     (pix_type'(req_tdata)),
      .geom    (geom),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .b_valid (b_valid),
      .b_ctl   (b_ctl),
      .b_hsum  (b_hsum)
   );

   brp_vaccum u_vaccum (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .b_valid   (b_valid),
      .b_ctl     (b_ctl),
      .b_hsum    (b_hsum),
      .push      (push),
      .push_word (push_word)
   );

   brp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_word  (out_word),
      .adv       (adv)
   );

   assign rsp_tdata    = 64'(out_word.res);
   assign rsp_tlast    = out_word.row_end;
   assign rsp_tuser[0] = out_word.frame_end;

endmodule

// ===== rtl/brp_checker.sv =====
// Port-level checks for binomial_pyramid_reduce, bound to the top level.
// Depends on binomial_pyramid_reduce port names only.
`timescale 1ns / 1ps

module brp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [0:0]  rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("frame end without row end");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled while output register empty");

endmodule

bind binomial_pyramid_reduce brp_checker u_brp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
